// File: rtl/bspv_pkg.sv
// ----------------------------------------------------------------------------
// bspv_pkg
// Shared types, constants and the soc/ocv curve for the plausibility voter.
// ----------------------------------------------------------------------------
package bspv_pkg;

  localparam int TABLE_MAX        = 32;
  localparam int CURVE_POINTS_DEF = 16;
  localparam int IDX_W            = $clog2(TABLE_MAX);

  localparam int VOLT_W = 23;
  localparam int CUR_W  = 24;
  localparam int SOC_W  = 11;
  localparam int SOCC_W = 10;
  localparam int CODE_W = 13;
  localparam int MV_W   = 13;
  localparam int VOTE_W = 4;

  localparam int RES_W   = 10;
  localparam int TOL_W   = 20;
  localparam int LIMIT_W = 23;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 2;

  localparam int DIV_W     = 24;
  localparam int DSR_W     = 10;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_VOTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = 2'd3;

  localparam logic [RES_W-1:0]   RES_RESET   = 10'd200;
  localparam logic [TOL_W-1:0]   TOL_RESET   = 20'd120000;
  localparam logic [VOTE_W-1:0]  VOTES_RESET = 4'd5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd200000;

  localparam logic [VOLT_W-1:0] OCV_MIN_UV      = 23'd3000000;
  localparam logic [VOLT_W-1:0] OCV_MAX_UV      = 23'd4300000;
  localparam logic [DSR_W-1:0]  OCV_LSB_UV      = 10'd550;
  localparam logic [DSR_W-1:0]  UA_PER_MA       = 10'd1000;
  localparam logic [DSR_W-1:0]  UV_PER_MV       = 10'd1000;
  localparam logic [SOC_W-1:0]  SOC_FULL_TENTHS = 11'd1000;
  localparam logic [SOC_W-1:0]  TENTHS_PER_BP   = 11'd5;

  // reciprocals for the divides by 1000 and by 550, exact over the field ranges
  localparam logic [24:0] MA_RECIP  = 25'd17179870;
  localparam int          MA_SHIFT  = 34;
  localparam logic [23:0] LSB_RECIP = 24'd15618063;
  localparam int          LSB_SHIFT = 33;

  localparam logic [1:0] REASON_NONE        = 2'd0;
  localparam logic [1:0] REASON_UNSEEDED    = 2'd1;
  localparam logic [1:0] REASON_IMPLAUSIBLE = 2'd2;

  localparam logic [MV_W-1:0] CURVE_MV [TABLE_MAX] = '{
    13'd3300, 13'd3450, 13'd3568, 13'd3640, 13'd3680, 13'd3700, 13'd3730, 13'd3750,
    13'd3790, 13'd3820, 13'd3870, 13'd3900, 13'd3940, 13'd4020, 13'd4100, 13'd4200,
    13'd4200, 13'd4200, 13'd4200, 13'd4200, 13'd4200, 13'd4200, 13'd4200, 13'd4200,
    13'd4200, 13'd4200, 13'd4200, 13'd4200, 13'd4200, 13'd4200, 13'd4200, 13'd4200
  };

  localparam logic [7:0] CURVE_HALF_PCT [TABLE_MAX] = '{
    8'h00, 8'h06, 8'h0c, 8'h14, 8'h1e, 8'h28, 8'h32, 8'h3c,
    8'h50, 8'h64, 8'h78, 8'h82, 8'h8c, 8'ha0, 8'hb4, 8'hc8,
    8'hc8, 8'hc8, 8'hc8, 8'hc8, 8'hc8, 8'hc8, 8'hc8, 8'hc8,
    8'hc8, 8'hc8, 8'hc8, 8'hc8, 8'hc8, 8'hc8, 8'hc8, 8'hc8
  };

  function automatic logic [SOC_W-1:0] soc_bp(input logic [IDX_W-1:0] idx);
    soc_bp = SOC_W'(CURVE_HALF_PCT[idx]) * TENTHS_PER_BP;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CUR_DIV,
    ST_IR,
    ST_OCV,
    ST_INTERP,
    ST_INTERP_WAIT,
    ST_EXP,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    KIND_UNSEED,
    KIND_NOREAD,
    KIND_UNSTEADY,
    KIND_STEADY
  } kind_t;

  typedef struct packed {
    logic [RES_W-1:0]   res_mohm;
    logic [TOL_W-1:0]   tol_uv;
    logic [VOTE_W-1:0]  votes_needed;
    logic [LIMIT_W-1:0] limit_ua;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              seed_request;
    logic [1:0]        seed_reason;
    logic [CODE_W-1:0] ocv_code;
    logic [VOLT_W-1:0] corrected_ocv_uv;
    logic [VOLT_W-1:0] expected_ocv_uv;
    logic              implausible;
    logic              steady;
    logic [VOTE_W-1:0] votes;
  } res_t;

endpackage

// File: rtl/bspv_div.sv
// ----------------------------------------------------------------------------
// bspv_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bspv_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bspv_pkg::div_req_t req,
  output bspv_pkg::div_rsp_t rsp
);
  import bspv_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     dvd_r;
  logic [DSR_W-1:0]     rem_r;
  logic [DSR_W-1:0]     dsr_r;

  logic [DSR_W:0]   sh;
  logic [DSR_W:0]   diff;
  logic             fits;
  logic [DSR_W-1:0] rem_nxt;
  logic [DIV_W-1:0] dvd_nxt;

  always_comb begin
    sh      = {rem_r, dvd_r[DIV_W-1]};
    diff    = sh - {1'b0, dsr_r};
    fits    = sh >= {1'b0, dsr_r};
    rem_nxt = fits ? diff[DSR_W-1:0] : sh[DSR_W-1:0];
    dvd_nxt = {dvd_r[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

// File: rtl/bspv_core.sv
// ----------------------------------------------------------------------------
// bspv_core
// Sequencer and datapath: steady check, ir correction, curve lookup, voting.
// ----------------------------------------------------------------------------
module bspv_core #(
  parameter int CurvePoints = bspv_pkg::CURVE_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [bspv_pkg::VOLT_W-1:0]        in_voltage_uv,
  input  logic signed [bspv_pkg::CUR_W-1:0]  in_current_ua,
  input  logic [bspv_pkg::SOC_W-1:0]         in_soc_tenths,
  input  bspv_pkg::cfg_t                     cfg,
  output logic                               res_valid,
  input  logic                               res_ready,
  output bspv_pkg::res_t                     res
);
  import bspv_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(CurvePoints - 1);

  state_t state_r, state_nxt;
  kind_t  kind_r;

  logic                    op_r;
  logic [VOLT_W-1:0]       volt_r;
  logic signed [CUR_W-1:0] cur_r;
  logic [SOCC_W-1:0]       soc_r;
  logic [IDX_W-1:0]        seg_r;
  logic                    seg_found_r;
  logic [13:0]             q_r;
  logic [CUR_W-1:0]        ir_mag_r;
  logic [VOLT_W-1:0]       ocv_r;
  logic [CUR_W-1:0]        slack_r;
  logic [MV_W-1:0]         exp_mv_r;
  logic [VOLT_W-1:0]       exp_r;
  logic                    impl_r;
  logic [CODE_W-1:0]       code_r;

  logic signed [CUR_W-1:0] prev_r, prev_nxt;
  logic [VOTE_W-1:0]       vc_r, vc_nxt;
  logic                    ns_r, ns_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [CUR_W:0]   cur_diff;
  logic [CUR_W:0]          cur_diff_mag;
  logic                    unsteady;
  logic [CUR_W-1:0]        cur_mag;
  logic [47:0]             ma_prod;
  logic [45:0]             code_prod;
  logic [IDX_W-1:0]        seg_c;
  logic                    found_c;
  logic [IDX_W-1:0]        seg_lo;
  logic [SOC_W-1:0]        bp_lo;
  logic [SOC_W-1:0]        bp_hi;
  logic                    use_div;
  logic [MV_W-1:0]         mv_flat;
  logic [DIV_W-1:0]        interp_num;
  logic [SOC_W-1:0]        interp_den;
  logic signed [25:0]      ocv_raw;
  logic [VOLT_W-1:0]       ocv_clamp;
  logic signed [VOLT_W:0]  cmp_diff;
  logic [VOLT_W-1:0]       cmp_mag;
  logic [VOTE_W-1:0]       vc_inc;

  bspv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // steady check and current magnitude
  always_comb begin
    cur_diff     = {cur_r[CUR_W-1], cur_r} - {prev_r[CUR_W-1], prev_r};
    cur_diff_mag = cur_diff[CUR_W] ? 25'(-cur_diff) : 25'(cur_diff);
    unsteady     = cur_diff_mag >= {2'b00, cfg.limit_ua};
    cur_mag      = cur_r[CUR_W-1] ? CUR_W'(-cur_r) : CUR_W'(cur_r);
  end

  // divide by 1000 and by 550 through reciprocal multiplication
  always_comb begin
    ma_prod   = 48'(cur_mag) * 48'(MA_RECIP);
    code_prod = 46'(ocv_r) * 46'(LSB_RECIP);
  end

  // curve segment search
  always_comb begin
    seg_c   = '0;
    found_c = 1'b0;
    for (int i = 1; i < TABLE_MAX; i++) begin
      if (!found_c && i < CurvePoints && {1'b0, soc_r} <= soc_bp(IDX_W'(i))) begin
        found_c = 1'b1;
        seg_c   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    seg_lo     = seg_r - 1'b1;
    bp_lo      = soc_bp(seg_lo);
    bp_hi      = soc_bp(seg_r);
    use_div    = seg_found_r && (bp_hi > bp_lo);
    mv_flat    = seg_found_r ? CURVE_MV[seg_r] : CURVE_MV[LastIdx];
    interp_num = DIV_W'(CURVE_MV[seg_r] - CURVE_MV[seg_lo]) *
                 DIV_W'({1'b0, soc_r} - bp_lo);
    interp_den = bp_hi - bp_lo;
  end

  // ir correction and clamp, and the magnitude of the ocv difference
  always_comb begin
    if (cur_r[CUR_W-1]) begin
      ocv_raw = 26'(volt_r) + 26'(ir_mag_r);
    end else begin
      ocv_raw = 26'(volt_r) - 26'(ir_mag_r);
    end
    if (ocv_raw < $signed(26'(OCV_MIN_UV))) begin
      ocv_clamp = OCV_MIN_UV;
    end else if (ocv_raw > $signed(26'(OCV_MAX_UV))) begin
      ocv_clamp = OCV_MAX_UV;
    end else begin
      ocv_clamp = ocv_raw[VOLT_W-1:0];
    end
    cmp_diff = {1'b0, ocv_r} - {1'b0, exp_r};
    cmp_mag  = cmp_diff[VOLT_W] ? VOLT_W'(-cmp_diff) : cmp_diff[VOLT_W-1:0];
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (state_r)
      ST_INTERP: begin
        div_req.start    = use_div;
        div_req.dividend = interp_num;
        div_req.divisor  = interp_den[DSR_W-1:0];
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer and result forming
  always_comb begin
    state_nxt = state_r;
    res_valid = 1'b0;
    res       = '0;
    res.votes = vc_r;
    prev_nxt  = prev_r;
    vc_nxt    = vc_r;
    ns_nxt    = ns_r;
    vc_inc    = vc_r + 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (op_r || volt_r == '0 || unsteady) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CUR_DIV;
        end
      end
      ST_CUR_DIV: begin
        state_nxt = ST_IR;
      end
      ST_IR: begin
        state_nxt = ST_OCV;
      end
      ST_OCV: begin
        state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        state_nxt = use_div ? ST_INTERP_WAIT : ST_EXP;
      end
      ST_INTERP_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_EXP;
        end
      end
      ST_EXP: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        case (kind_r)
          KIND_UNSEED: begin
            ns_nxt = 1'b1;
          end
          KIND_NOREAD: begin
            ns_nxt = ns_r;
          end
          KIND_UNSTEADY: begin
            prev_nxt  = cur_r;
            vc_nxt    = '0;
            res.votes = '0;
          end
          KIND_STEADY: begin
            prev_nxt             = cur_r;
            res.ocv_code         = code_r;
            res.corrected_ocv_uv = ocv_r;
            res.expected_ocv_uv  = exp_r;
            res.implausible      = impl_r;
            res.steady           = 1'b1;
            if (!ns_r && !impl_r) begin
              vc_nxt = '0;
            end else if (vc_inc >= cfg.votes_needed) begin
              vc_nxt           = '0;
              ns_nxt           = 1'b0;
              res.seed_request = 1'b1;
              res.seed_reason  = ns_r ? REASON_UNSEEDED : REASON_IMPLAUSIBLE;
            end else begin
              vc_nxt = vc_inc;
            end
            res.votes = vc_nxt;
          end
          default: begin
            ns_nxt = ns_r;
          end
        endcase
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = state_r != ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      vc_r   <= '0;
      ns_r   <= 1'b0;
    end else if (state_r == ST_DONE && res_ready) begin
      prev_r <= prev_nxt;
      vc_r   <= vc_nxt;
      ns_r   <= ns_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_r   <= in_op;
          volt_r <= in_voltage_uv;
          cur_r  <= in_current_ua;
          soc_r  <= (in_soc_tenths > SOC_FULL_TENTHS) ? SOC_FULL_TENTHS[SOCC_W-1:0]
                                                      : in_soc_tenths[SOCC_W-1:0];
        end
      end
      ST_CHECK: begin
        seg_r       <= seg_c;
        seg_found_r <= found_c;
        if (op_r) begin
          kind_r <= KIND_UNSEED;
        end else if (volt_r == '0) begin
          kind_r <= KIND_NOREAD;
        end else if (unsteady) begin
          kind_r <= KIND_UNSTEADY;
        end else begin
          kind_r <= KIND_STEADY;
        end
      end
      ST_CUR_DIV: begin
        q_r <= ma_prod[47:MA_SHIFT];
      end
      ST_IR: begin
        ir_mag_r <= CUR_W'(q_r) * CUR_W'(cfg.res_mohm);
      end
      ST_OCV: begin
        ocv_r   <= ocv_clamp;
        slack_r <= CUR_W'(cfg.tol_uv) + CUR_W'(ir_mag_r >> 1);
      end
      ST_INTERP: begin
        if (!use_div) begin
          exp_mv_r <= mv_flat;
        end
      end
      ST_INTERP_WAIT: begin
        if (div_rsp.done) begin
          exp_mv_r <= CURVE_MV[seg_lo] + div_rsp.quotient[MV_W-1:0];
        end
      end
      ST_EXP: begin
        exp_r <= VOLT_W'(exp_mv_r) * VOLT_W'(UV_PER_MV);
      end
      ST_CMP: begin
        impl_r <= {1'b0, cmp_mag} > slack_r;
        code_r <= code_prod[45:LSB_SHIFT];
      end
      default: begin
        op_r <= op_r;
      end
    endcase
  end

endmodule

// File: rtl/battery_soc_plausibility_voter.sv
// ----------------------------------------------------------------------------
// battery_soc_plausibility_voter
// Votes on the plausibility of a gauge soc against the ir-corrected ocv.
// ----------------------------------------------------------------------------
// one request at a time; a steady sample passes the check, current divide, ir, ocv,
// interpolation, expected and compare states, and the curve interpolation waits for
// one 24-step pass of the serial divider when a segment is found with distinct breakpoints
// unseed, no-reading and unsteady requests go from the check state straight to the result
// a result held by a stalled output register holds off the next request
// synchronous active-low reset clears config to defaults, state and vote counter
module battery_soc_plausibility_voter #(
  parameter int CurvePoints = bspv_pkg::CURVE_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [bspv_pkg::VOLT_W-1:0]          in_voltage_uv,
  input  logic signed [bspv_pkg::CUR_W-1:0]    in_current_ua,
  input  logic [bspv_pkg::SOC_W-1:0]           in_soc_tenths,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_seed_request,
  output logic [1:0]                           out_seed_reason,
  output logic [bspv_pkg::CODE_W-1:0]          out_ocv_code,
  output logic [bspv_pkg::VOLT_W-1:0]          out_corrected_ocv_uv,
  output logic [bspv_pkg::VOLT_W-1:0]          out_expected_ocv_uv,
  output logic                                 out_implausible,
  output logic                                 out_steady,
  output logic [bspv_pkg::VOTE_W-1:0]          out_votes,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bspv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bspv_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bspv_pkg::*;

  cfg_t cfg_r;
  res_t res;
  res_t out_r;
  logic out_valid_r;
  logic res_valid;
  logic res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.res_mohm     <= RES_RESET;
      cfg_r.tol_uv       <= TOL_RESET;
      cfg_r.votes_needed <= VOTES_RESET;
      cfg_r.limit_ua     <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_RES:   cfg_r.res_mohm     <= cfg_data[RES_W-1:0];
        CFG_IDX_TOL:   cfg_r.tol_uv       <= cfg_data[TOL_W-1:0];
        CFG_IDX_VOTES: cfg_r.votes_needed <= cfg_data[VOTE_W-1:0];
        CFG_IDX_LIMIT: cfg_r.limit_ua     <= cfg_data[LIMIT_W-1:0];
        default:       cfg_r              <= cfg_r;
      endcase
    end
  end

  bspv_core #(
    .CurvePoints (CurvePoints)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_voltage_uv (in_voltage_uv),
    .in_current_ua (in_current_ua),
    .in_soc_tenths (in_soc_tenths),
    .cfg           (cfg_r),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // output register
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_seed_request     = out_r.seed_request;
  assign out_seed_reason      = out_r.seed_reason;
  assign out_ocv_code         = out_r.ocv_code;
  assign out_corrected_ocv_uv = out_r.corrected_ocv_uv;
  assign out_expected_ocv_uv  = out_r.expected_ocv_uv;
  assign out_implausible      = out_r.implausible;
  assign out_steady           = out_r.steady;
  assign out_votes            = out_r.votes;

endmodule

// File: sim/battery_soc_plausibility_voter_tb.sv
// ----------------------------------------------------------------------------
// battery_soc_plausibility_voter_tb
// Self-checking bench: drives sample requests and register writes, predicts
// each verdict with an in-bench model of the vote logic and checks every
// field of every result in order, under changing settings and back-pressure.
// ----------------------------------------------------------------------------
module battery_soc_plausibility_voter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bspv_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_UNSEED = 1'b1;
  localparam int CUR_MAX = 8388607;
  localparam int CUR_MIN = -8388608;
  localparam int VOLT_MAX = 8388607;

  typedef struct packed {
    logic              op;
    logic [VOLT_W-1:0] voltage_uv;
    logic [CUR_W-1:0]  current_ua;
    logic [SOC_W-1:0]  soc_tenths;
  } sample_t;

  class reseed_vote_board;
    logic [RES_W-1:0]   res_mohm;
    logic [TOL_W-1:0]   tol_uv;
    logic [VOTE_W-1:0]  votes_needed;
    logic [LIMIT_W-1:0] limit_ua;
    int                 last_current;
    logic [VOTE_W-1:0]  vote_count;
    bit                 needs_seed;
    res_t               awaited_verdicts[$];
    int                 mismatches;

    function new();
      res_mohm     = RES_RESET;
      tol_uv       = TOL_RESET;
      votes_needed = VOTES_RESET;
      limit_ua     = LIMIT_RESET;
      last_current = 0;
      vote_count   = '0;
      needs_seed   = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_IDX_RES:   res_mohm     = value[RES_W-1:0];
        CFG_IDX_TOL:   tol_uv       = value[TOL_W-1:0];
        CFG_IDX_VOTES: votes_needed = value[VOTE_W-1:0];
        CFG_IDX_LIMIT: limit_ua     = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function int abs_int(int v);
      return (v < 0) ? -v : v;
    endfunction

    function int ocv_from_soc(int soc);
      int s, lo, hi, lo_mv, hi_mv, points, i;
      points = CURVE_POINTS_DEF;
      if (points < 2) points = 2;
      if (points > TABLE_MAX) points = TABLE_MAX;
      s = (soc > int'(SOC_FULL_TENTHS)) ? int'(SOC_FULL_TENTHS) : soc;
      for (i = 1; i < points; i++) begin
        lo = int'(CURVE_HALF_PCT[i-1]) * int'(TENTHS_PER_BP);
        hi = int'(CURVE_HALF_PCT[i]) * int'(TENTHS_PER_BP);
        if (s <= hi) begin
          lo_mv = int'(CURVE_MV[i-1]);
          hi_mv = int'(CURVE_MV[i]);
          if (hi <= lo) return hi_mv * int'(UV_PER_MV);
          return (lo_mv + (hi_mv - lo_mv) * (s - lo) / (hi - lo)) * int'(UV_PER_MV);
        end
      end
      return int'(CURVE_MV[points-1]) * int'(UV_PER_MV);
    endfunction

    function res_t predict_verdict(sample_t s);
      res_t r;
      int   cur, step, ir, ocv, want, slack;
      bit   off_curve;
      r = '0;
      if (s.op == OP_UNSEED) begin
        needs_seed = 1'b1;
        r.votes = vote_count;
        return r;
      end
      if (s.voltage_uv == '0) begin
        r.votes = vote_count;
        return r;
      end
      cur = int'($signed(s.current_ua));
      step = abs_int(cur - last_current);
      last_current = cur;
      if (step >= int'(limit_ua)) begin
        vote_count = '0;
        return r;
      end
      ir = (cur / int'(UA_PER_MA)) * int'(res_mohm);
      ocv = int'(s.voltage_uv) - ir;
      if (ocv < int'(OCV_MIN_UV)) ocv = int'(OCV_MIN_UV);
      if (ocv > int'(OCV_MAX_UV)) ocv = int'(OCV_MAX_UV);
      want = ocv_from_soc(int'(s.soc_tenths));
      slack = int'(tol_uv) + abs_int(ir) / 2;
      off_curve = abs_int(ocv - want) > slack;
      r.ocv_code         = CODE_W'(ocv / int'(OCV_LSB_UV));
      r.corrected_ocv_uv = VOLT_W'(ocv);
      r.expected_ocv_uv  = VOLT_W'(want);
      r.implausible      = off_curve;
      r.steady           = 1'b1;
      if (!needs_seed && !off_curve) begin
        vote_count = '0;
      end else begin
        vote_count = vote_count + 1'b1;
        if (vote_count >= votes_needed) begin
          r.seed_request = 1'b1;
          r.seed_reason  = needs_seed ? REASON_UNSEEDED : REASON_IMPLAUSIBLE;
          needs_seed     = 1'b0;
          vote_count     = '0;
        end
      end
      r.votes = vote_count;
      return r;
    endfunction

    function void note_sample(sample_t s);
      awaited_verdicts.push_back(predict_verdict(s));
    endfunction

    function int pending();
      return awaited_verdicts.size();
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_verdict(res_t got);
      res_t want;
      if (awaited_verdicts.size() == 0) begin
        $error("result arrived with no request pending");
        mismatches++;
        return;
      end
      want = awaited_verdicts.pop_front();
      compare_field("seed_request", want.seed_request, got.seed_request);
      compare_field("seed_reason", want.seed_reason, got.seed_reason);
      compare_field("ocv_code", want.ocv_code, got.ocv_code);
      compare_field("corrected_ocv_uv", want.corrected_ocv_uv, got.corrected_ocv_uv);
      compare_field("expected_ocv_uv", want.expected_ocv_uv, got.expected_ocv_uv);
      compare_field("implausible", want.implausible, got.implausible);
      compare_field("steady", want.steady, got.steady);
      compare_field("votes", want.votes, got.votes);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_op = OP_SAMPLE;
  logic [VOLT_W-1:0]     in_voltage_uv = '0;
  logic signed [CUR_W-1:0] in_current_ua = '0;
  logic [SOC_W-1:0]      in_soc_tenths = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_seed_request;
  logic [1:0]            out_seed_reason;
  logic [CODE_W-1:0]     out_ocv_code;
  logic [VOLT_W-1:0]     out_corrected_ocv_uv;
  logic [VOLT_W-1:0]     out_expected_ocv_uv;
  logic                  out_implausible;
  logic                  out_steady;
  logic [VOTE_W-1:0]     out_votes;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  reseed_vote_board board = new();
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   cycle_count = 0;
  res_t seen;

  battery_soc_plausibility_voter DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_voltage_uv        (in_voltage_uv),
    .in_current_ua        (in_current_ua),
    .in_soc_tenths        (in_soc_tenths),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_seed_request     (out_seed_request),
    .out_seed_reason      (out_seed_reason),
    .out_ocv_code         (out_ocv_code),
    .out_corrected_ocv_uv (out_corrected_ocv_uv),
    .out_expected_ocv_uv  (out_expected_ocv_uv),
    .out_implausible      (out_implausible),
    .out_steady           (out_steady),
    .out_votes            (out_votes),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_seed_request, out_seed_reason, out_ocv_code, out_corrected_ocv_uv,
              out_expected_ocv_uv, out_implausible, out_steady, out_votes};
      board.check_verdict(seen);
    end
  end

  function automatic sample_t pack_sample(logic op, int volt, int cur, int soc);
    sample_t s;
    s.op         = op;
    s.voltage_uv = VOLT_W'(volt);
    s.current_ua = CUR_W'(cur);
    s.soc_tenths = SOC_W'(soc);
    return s;
  endfunction

  task automatic send_sample(sample_t s);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (send_idle_pct > 0 && $urandom_range(99) < 4) gap += $urandom_range(1, 120);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= s.op;
    in_voltage_uv <= s.voltage_uv;
    in_current_ua <= s.current_ua;
    in_soc_tenths <= s.soc_tenths;
    do @(posedge clk); while (in_stall);
    board.note_sample(s);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, CFG_DATA_W'(value));
  endtask

  task automatic start_phase(int idle_pct, int hold_pct, int res, int tol, int votes,
                             int limit);
    wait_drained();
    repeat (8) @(posedge clk);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    write_reg(CFG_IDX_RES, res);
    write_reg(CFG_IDX_TOL, tol);
    write_reg(CFG_IDX_VOTES, votes);
    write_reg(CFG_IDX_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    int k;
    send_sample(pack_sample(OP_UNSEED, 4000000, 123, 77));
    send_sample(pack_sample(OP_SAMPLE, 0, CUR_MAX, 1280));
    send_sample(pack_sample(OP_SAMPLE, 3700000, CUR_MAX, 600));
    send_sample(pack_sample(OP_SAMPLE, 3700000, CUR_MIN, 600));
    send_sample(pack_sample(OP_SAMPLE, 2000000, CUR_MIN, 0));
    send_sample(pack_sample(OP_SAMPLE, 3820000, 0, 500));
    for (k = 0; k < 6; k++) send_sample(pack_sample(OP_SAMPLE, 3820000, 0, 500));
    for (k = 0; k < 5; k++) begin
      send_sample(pack_sample(OP_SAMPLE, 4300000, (k % 2) ? -100 : 100, 0));
    end
    send_sample(pack_sample(OP_SAMPLE, VOLT_MAX, 0, 1280));
    send_sample(pack_sample(OP_SAMPLE, 1, 0, 1000));
    send_sample(pack_sample(OP_SAMPLE, 3300000, 0, 0));
    send_sample(pack_sample(OP_SAMPLE, 4200000, 999, 1024));
    send_sample(pack_sample(OP_SAMPLE, 4100000, -999, 700));
    send_sample(pack_sample(OP_UNSEED, 0, -1, 1280));
  endtask

  task automatic run_random(int count, int pause_every);
    sample_t s;
    int made, burst_left, base, soc, cur, dmax, ir, off, volt, pick;
    bit off_curve;
    made = 0;
    burst_left = 0;
    base = 0;
    soc = 0;
    off_curve = 1'b0;
    while (made < count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 18);
        soc = $urandom_range(0, 1280);
        off_curve = $urandom_range(99) < 50;
        pick = $urandom_range(99);
        if (pick < 60) base = int'($urandom_range(0, 4000000)) - 2000000;
        else if (pick < 85) base = int'($urandom_range(0, 16777215)) + CUR_MIN;
        else if (pick < 93) base = CUR_MAX - int'($urandom_range(0, 100000));
        else base = CUR_MIN + int'($urandom_range(0, 100000));
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        s.op         = OP_SAMPLE;
        s.voltage_uv = ($urandom_range(99) < 15) ? '0 : VOLT_W'($urandom_range(1, VOLT_MAX));
        s.current_ua = CUR_W'($urandom);
        s.soc_tenths = SOC_W'($urandom_range(0, 1280));
      end else if (pick < 13) begin
        s.op         = OP_UNSEED;
        s.voltage_uv = VOLT_W'($urandom);
        s.current_ua = CUR_W'($urandom);
        s.soc_tenths = SOC_W'($urandom_range(0, 1280));
      end else begin
        dmax = (board.limit_ua > 1) ? int'((board.limit_ua - 1) / 2) : 0;
        if (dmax > 60000) dmax = 60000;
        cur = base + int'($urandom_range(0, 2 * dmax)) - dmax;
        if (cur > CUR_MAX) cur = CUR_MAX;
        if (cur < CUR_MIN) cur = CUR_MIN;
        ir = (cur / 1000) * int'(board.res_mohm);
        if (off_curve) begin
          off = int'(board.tol_uv) + board.abs_int(ir) / 2 + 1
                + int'($urandom_range(0, 400000));
        end else begin
          off = int'($urandom_range(0, board.tol_uv / 2));
        end
        if ($urandom_range(1)) off = -off;
        volt = board.ocv_from_soc(soc) + ir + off;
        if (volt < 1) volt = 1;
        if (volt > VOLT_MAX) volt = VOLT_MAX;
        s = pack_sample(OP_SAMPLE, volt, cur, soc);
        burst_left--;
      end
      send_sample(s);
      if (s.op == OP_UNSEED || s.voltage_uv != '0) made++;
      if (pause_every > 0 && made % pause_every == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    start_phase(0, 0, 0, 0, 1, 8388607);
    run_random(220, 0);
    start_phase(70, 0, 1023, 1048575, 15, 200000);
    run_random(220, 0);
    start_phase(0, 70, RES_RESET, TOL_RESET, VOTES_RESET, LIMIT_RESET);
    run_random(220, 0);
    start_phase(18, 18, $urandom_range(0, 1023), $urandom_range(0, 300000), 0,
                $urandom_range(1000, 2000000));
    run_random(200, 0);
    start_phase(0, 0, 512, 50000, 3, 0);
    run_random(40, 0);
    start_phase(18, 18, $urandom_range(0, 1023), $urandom_range(0, 1048575),
                $urandom_range(1, 15), 500000);
    run_random(220, 30);
    wait_drained();
    repeat (100) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
